>>> hw/rtl/ip_ban_table_matcher_defines.svh
// Assertion helpers for the RTL file that carries concurrent checks.
`ifndef IP_BAN_TABLE_MATCHER_DEFINES_SVH
`define IP_BAN_TABLE_MATCHER_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define IBT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define IBT_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ibt_pkg.sv
`timescale 1ns / 1ps

package ibt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int WORD_W      = 32;

    localparam logic [CNT_W-1:0] DEPTH_COUNT = CNT_W'(TABLE_DEPTH);

    // stream payload widths
    localparam int KIND_W       = 2;
    localparam int IN_FIELDS_W  = 4 * WORD_W + IDX_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 + CNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    typedef enum logic [KIND_W-1:0] {
        REQ_ADD   = 2'd0,
        REQ_DEL   = 2'd1,
        REQ_CHECK = 2'd2
    } ibt_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SHIFT,
        ST_SCAN,
        ST_DONE
    } ibt_state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] expiry;
        logic [WORD_W-1:0] now;
        logic [IDX_W-1:0]  idx;
    } ibt_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] expiry;
    } ibt_entry_t;

    typedef struct packed {
        logic             ok;
        logic             banned;
        logic [CNT_W-1:0] entry_count;
    } ibt_result_t;

endpackage

>>> hw/rtl/ip_ban_table_matcher.sv
`timescale 1ns / 1ps
// Ordered ban table with add, delete-at-index and prefix check requests.
// Input channel s_axis_*: one request item per handshake; tuser carries the
// request kind (0 add, 1 delete, 2 check), tdata the operands.
// Output channel m_axis_*: exactly one result item per request, in order,
// carrying ok, banned and the entry count after the request.
// Work per request, with N entries stored: an add writes the new entry to the
// tail slot; a delete at index i moves the N - i - 1 entries above it down one
// slot; a check reads all N entries. The next request is taken once the
// sequencer is back in idle after the result load. The entry RAM has a single
// read port, which the check scan and the delete shift walk one entry per cycle.
// Requests are taken one at a time: s_axis_tready is high only while the
// sequencer is idle. A finished result sits in the output register, so the
// next request is accepted while that result waits for m_axis_tready; a
// further result holds inside the sequencer until the register frees up.
// Reset (aresetn low, synchronous) empties the table and drops any pending
// result; entry contents are not cleared, only the entry count.
// Table depth is 64 entries.

`include "ip_ban_table_matcher_defines.svh"

module ip_ban_table_matcher (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // addr [31:0], addr_mask [63:32], expiry [95:64], current_time [127:96],
    // entry_index [133:128], zero padding above
    input  logic [ibt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // req_type [1:0]
    input  logic [ibt_pkg::KIND_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // ok [0], banned [1], entry_count [8:2], zero padding above
    output logic [ibt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int W = ibt_pkg::WORD_W;

    ibt_pkg::ibt_req_t    req;
    ibt_pkg::ibt_result_t ctrl_res;
    logic                 ctrl_res_valid;
    logic                 res_ready;

    logic                 m_valid_reg, m_valid_next;
    ibt_pkg::ibt_result_t m_data_reg, m_data_next;

    // unpack the request item
    assign req = '{
        kind:   s_axis_tuser,
        addr:   s_axis_tdata[W-1:0],
        mask:   s_axis_tdata[2*W-1:W],
        expiry: s_axis_tdata[3*W-1:2*W],
        now:    s_axis_tdata[4*W-1:3*W],
        idx:    s_axis_tdata[4*W+ibt_pkg::IDX_W-1:4*W]
    };

    ibt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req       (req),
        .res_valid (ctrl_res_valid),
        .res_ready (res_ready),
        .res       (ctrl_res)
    );

    // output register: load when empty or when the held item leaves this cycle
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (ctrl_res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = ctrl_res;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{ibt_pkg::OUT_PAD_W{1'b0}}, m_data_reg.entry_count,
                            m_data_reg.banned, m_data_reg.ok};

    // entry count never runs past the table depth
    `IBT_ASSERT_IMP(a_count_in_range, aclk, aresetn, 1'b1, ctrl_res.entry_count <= ibt_pkg::DEPTH_COUNT, "entry count above table depth")

    // a banned result only comes from a successful check
    `IBT_ASSERT_IMP(a_banned_needs_ok, aclk, aresetn, m_valid_reg && m_data_reg.banned, m_data_reg.ok, "banned result without ok")

    // an accepted request leaves the sequencer busy in the next cycle
    `IBT_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while busy")

    // a finished result waits in the sequencer until the output register takes it
    `IBT_ASSERT_NXT(a_result_held, aclk, aresetn, ctrl_res_valid && !res_ready, ctrl_res_valid, "pending result dropped")

endmodule

>>> hw/rtl/ibt_table_ram.sv
`timescale 1ns / 1ps

module ibt_table_ram (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [ibt_pkg::IDX_W-1:0] wr_addr,
    input  ibt_pkg::ibt_entry_t      wr_data,
    input  logic                     rd_en,
    input  logic [ibt_pkg::IDX_W-1:0] rd_addr,
    output ibt_pkg::ibt_entry_t      rd_data
);

    ibt_pkg::ibt_entry_t mem [ibt_pkg::TABLE_DEPTH];
    ibt_pkg::ibt_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/ibt_ctrl.sv
`timescale 1ns / 1ps

module ibt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  ibt_pkg::ibt_req_t    req,
    output logic                 res_valid,
    input  logic                 res_ready,
    output ibt_pkg::ibt_result_t res
);

    ibt_pkg::ibt_state_t state_reg, state_next;
    ibt_pkg::ibt_req_t   req_reg, req_next;
    logic [ibt_pkg::CNT_W-1:0] count_reg, count_next;
    logic [ibt_pkg::CNT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ibt_pkg::IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic rvalid_reg, rvalid_next;
    logic ok_reg, ok_next;
    logic hit_reg, hit_next;

    logic                      ram_wr_en;
    logic [ibt_pkg::IDX_W-1:0] ram_wr_addr;
    ibt_pkg::ibt_entry_t       ram_wr_data;
    logic                      ram_rd_en;
    ibt_pkg::ibt_entry_t       ram_rd_data;
    logic                      entry_hit;
    logic                      more_reads;

    ibt_table_ram u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_ptr_reg[ibt_pkg::IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // live prefix match on the entry returned by the RAM this cycle
    assign entry_hit =
        ((req_reg.addr & ram_rd_data.mask) == (ram_rd_data.addr & ram_rd_data.mask)) &&
        ((ram_rd_data.expiry == '0) || (ram_rd_data.expiry >= req_reg.now));

    assign more_reads = (rd_ptr_reg < count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ibt_pkg::ST_IDLE;
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        rd_ptr_reg <= rd_ptr_next;
        wr_ptr_reg <= wr_ptr_next;
        ok_reg     <= ok_next;
        hit_reg    <= hit_next;
    end

    always_comb begin
        state_next  = state_reg;
        req_next    = req_reg;
        count_next  = count_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        rvalid_next = rvalid_reg;
        ok_next     = ok_reg;
        hit_next    = hit_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = wr_ptr_reg;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        req_ready   = 1'b0;
        res_valid   = 1'b0;

        unique case (state_reg)
            ibt_pkg::ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    req_next   = req;
                    state_next = ibt_pkg::ST_EXEC;
                end
            end
            ibt_pkg::ST_EXEC: begin
                hit_next    = 1'b0;
                rvalid_next = 1'b0;
                unique case (req_reg.kind)
                    ibt_pkg::REQ_ADD: begin
                        // append at the tail when there is room
                        ok_next    = (count_reg < ibt_pkg::DEPTH_COUNT);
                        state_next = ibt_pkg::ST_DONE;
                        if (count_reg < ibt_pkg::DEPTH_COUNT) begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = count_reg[ibt_pkg::IDX_W-1:0];
                            ram_wr_data = '{addr: req_reg.addr, mask: req_reg.mask,
                                            expiry: req_reg.expiry};
                            count_next  = count_reg + ibt_pkg::CNT_W'(1);
                        end
                    end
                    ibt_pkg::REQ_DEL: begin
                        if (ibt_pkg::CNT_W'(req_reg.idx) < count_reg) begin
                            ok_next     = 1'b1;
                            rd_ptr_next = ibt_pkg::CNT_W'(req_reg.idx) + ibt_pkg::CNT_W'(1);
                            wr_ptr_next = req_reg.idx;
                            state_next  = ibt_pkg::ST_SHIFT;
                        end else begin
                            ok_next    = 1'b0;
                            state_next = ibt_pkg::ST_DONE;
                        end
                    end
                    ibt_pkg::REQ_CHECK: begin
                        ok_next     = 1'b1;
                        rd_ptr_next = '0;
                        state_next  = ibt_pkg::ST_SCAN;
                    end
                    default: begin
                        ok_next    = 1'b0;
                        state_next = ibt_pkg::ST_DONE;
                    end
                endcase
            end
            ibt_pkg::ST_SHIFT: begin
                // read slot k+1 while writing back the slot read last cycle
                if (rvalid_reg) begin
                    ram_wr_en   = 1'b1;
                    wr_ptr_next = wr_ptr_reg + ibt_pkg::IDX_W'(1);
                end
                if (more_reads) begin
                    ram_rd_en   = 1'b1;
                    rd_ptr_next = rd_ptr_reg + ibt_pkg::CNT_W'(1);
                    rvalid_next = 1'b1;
                end else begin
                    rvalid_next = 1'b0;
                    if (!rvalid_reg) begin
                        count_next = count_reg - ibt_pkg::CNT_W'(1);
                        state_next = ibt_pkg::ST_DONE;
                    end
                end
            end
            ibt_pkg::ST_SCAN: begin
                if (rvalid_reg && entry_hit) begin
                    hit_next = 1'b1;
                end
                if (more_reads) begin
                    ram_rd_en   = 1'b1;
                    rd_ptr_next = rd_ptr_reg + ibt_pkg::CNT_W'(1);
                    rvalid_next = 1'b1;
                end else begin
                    rvalid_next = 1'b0;
                    if (!rvalid_reg) begin
                        state_next = ibt_pkg::ST_DONE;
                    end
                end
            end
            ibt_pkg::ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ibt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ibt_pkg::ST_IDLE;
            end
        endcase
    end

    assign res = '{ok: ok_reg, banned: hit_reg, entry_count: count_reg};

endmodule

>>> sim/tb_ip_ban_table_matcher.sv
`timescale 1ns / 1ps

module tb_ip_ban_table_matcher;

    // Kind code with no meaning; the block must ignore it and still answer.
    localparam logic [ibt_pkg::KIND_W-1:0] REQ_UNUSED = 2'd3;

    // Slowest item is a check over a full table plus the longest gap and stall;
    // take that over ~2000 items, times five.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Drain time after the last expected item: one full-table scan and margin.
    localparam int DRAIN_CYCLES = 100;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [ibt_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [ibt_pkg::KIND_W-1:0]      s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b1;
    logic [ibt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    ip_ban_table_matcher dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow copy of the ban list, kept in step with every accepted item.
    ibt_pkg::ibt_entry_t  ban_list [ibt_pkg::TABLE_DEPTH];
    int                   ban_count = 0;
    // Verdicts owed by the block, oldest first.
    ibt_pkg::ibt_result_t pending_verdicts [$];

    int          error_count = 0;
    int          cycle_count = 0;
    bit          idle_en = 1'b1;
    int          stall_left = 0;
    logic [31:0] clock_now = '0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Apply one request to the shadow list and return the verdict it owes.
    function automatic ibt_pkg::ibt_result_t ban_table_apply(
        logic [ibt_pkg::KIND_W-1:0] kind,
        logic [31:0] addr, mask, expiry, t_now,
        logic [ibt_pkg::IDX_W-1:0] idx
    );
        ibt_pkg::ibt_result_t res;
        res = '0;
        case (kind)
            ibt_pkg::REQ_ADD: begin
                if (ban_count < ibt_pkg::TABLE_DEPTH) begin
                    ban_list[ban_count].addr   = addr;
                    ban_list[ban_count].mask   = mask;
                    ban_list[ban_count].expiry = expiry;
                    ban_count++;
                    res.ok = 1'b1;
                end
            end
            ibt_pkg::REQ_DEL: begin
                if (int'(idx) < ban_count) begin
                    // close the gap: every later entry moves down one slot
                    for (int k = int'(idx); k + 1 < ban_count; k++)
                        ban_list[k] = ban_list[k + 1];
                    ban_count--;
                    res.ok = 1'b1;
                end
            end
            ibt_pkg::REQ_CHECK: begin
                res.ok = 1'b1;
                for (int k = 0; k < ban_count; k++) begin
                    if ((addr & ban_list[k].mask) == (ban_list[k].addr & ban_list[k].mask) &&
                        (ban_list[k].expiry == 32'd0 || ban_list[k].expiry >= t_now))
                        res.banned = 1'b1;
                end
            end
            default: ;
        endcase
        res.entry_count = ibt_pkg::CNT_W'(ban_count);
        return res;
    endfunction

    function automatic logic [31:0] prefix_mask(int len);
        return (len == 0) ? 32'h0 : 32'hFFFF_FFFF << (32 - len);
    endfunction

    // Mostly long prefixes so that checks can miss; some short or arbitrary masks.
    function automatic logic [31:0] random_mask();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return prefix_mask($urandom_range(0, 32));
            default: return prefix_mask($urandom_range(20, 32));
        endcase
    endfunction

    // Expiry around the running clock so both live and expired entries occur.
    function automatic logic [31:0] pick_expiry();
        case ($urandom_range(0, 7))
            0, 1:    return 32'd0;
            2:       return $urandom;
            default: return clock_now + 32'($urandom_range(0, 300)) - 32'd100;
        endcase
    endfunction

    // Send one request item: optional gap, drive at the falling edge, hold until
    // accepted, then record the verdict it owes.
    task automatic send_item(
        logic [ibt_pkg::KIND_W-1:0] kind,
        logic [31:0] addr, mask, expiry, t_now,
        logic [ibt_pkg::IDX_W-1:0] idx
    );
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            repeat (gap) begin
                @(negedge aclk);
                s_axis_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= ibt_pkg::IN_TDATA_W'({idx, t_now, expiry, mask, addr});
        do @(posedge aclk); while (!s_axis_tready);
        pending_verdicts.push_back(ban_table_apply(kind, addr, mask, expiry, t_now, idx));
    endtask

    // One random request; fill_bias tilts the mix toward adds, else toward deletes.
    task automatic send_random_request(bit fill_bias);
        int unsigned pick;
        int unsigned w_add;
        int unsigned w_del;
        int          k;
        logic [31:0] probe;
        logic [31:0] t_now;
        logic [ibt_pkg::IDX_W-1:0] idx;
        clock_now = clock_now + 32'($urandom_range(0, 3));
        w_add = fill_bias ? 45 : 15;
        w_del = fill_bias ? 15 : 45;
        pick  = $urandom_range(0, 99);
        if (pick < 3) begin
            send_item(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom,
                      ibt_pkg::IDX_W'($urandom));
        end else if (pick < 3 + w_add) begin
            send_item(ibt_pkg::REQ_ADD, $urandom, random_mask(), pick_expiry(), $urandom,
                      ibt_pkg::IDX_W'($urandom));
        end else if (pick < 3 + w_add + w_del) begin
            // mostly valid positions, now and then any index
            if (ban_count != 0 && $urandom_range(0, 4) != 0)
                idx = ibt_pkg::IDX_W'($urandom_range(0, ban_count - 1));
            else
                idx = ibt_pkg::IDX_W'($urandom_range(0, ibt_pkg::TABLE_DEPTH - 1));
            send_item(ibt_pkg::REQ_DEL, $urandom, $urandom, $urandom, $urandom, idx);
        end else begin
            probe = $urandom;
            t_now = ($urandom_range(0, 7) == 0) ? 32'($urandom) : clock_now;
            if (ban_count != 0 && $urandom_range(0, 9) < 7) begin
                // aim at a stored entry: vary only the bits outside its mask
                k = $urandom_range(0, ban_count - 1);
                probe = ban_list[k].addr ^ (32'($urandom) & ~ban_list[k].mask);
                // sometimes break the match on one masked bit
                if ($urandom_range(0, 3) == 0)
                    probe ^= ban_list[k].mask & (32'h1 << $urandom_range(0, 31));
                // land on the expiry boundary: one before, equal, one after
                if ($urandom_range(0, 1) == 0)
                    t_now = ban_list[k].expiry + 32'($urandom_range(0, 2)) - 32'd1;
            end
            send_item(ibt_pkg::REQ_CHECK, probe, $urandom, $urandom, t_now,
                      ibt_pkg::IDX_W'($urandom));
        end
    endtask

    // Edge cases on a nearly empty table.
    task automatic test_directed_cases();
        send_item(ibt_pkg::REQ_CHECK, 32'h0, 32'h0, 32'h0, 32'h0, '0);  // empty table check
        send_item(ibt_pkg::REQ_DEL, 32'h0, 32'h0, 32'h0, 32'h0, '0);    // delete on empty
        send_item(REQ_UNUSED, '1, '1, '1, '1, '1);                       // meaningless kind
        // exact-match entry that never expires
        send_item(ibt_pkg::REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, '1);
        send_item(ibt_pkg::REQ_CHECK, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, '0);
        send_item(ibt_pkg::REQ_CHECK, 32'hFFFF_FFFE, 32'h0, 32'h0, 32'h0, '0);
        // /8 prefix expiring at 1000
        send_item(ibt_pkg::REQ_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'd1000, 32'h0, '0);
        send_item(ibt_pkg::REQ_CHECK, 32'h0A12_3456, 32'h0, 32'h0, 32'd1000, '0);  // == now
        send_item(ibt_pkg::REQ_CHECK, 32'h0A12_3456, 32'h0, 32'h0, 32'd1001, '0);  // expired
        send_item(ibt_pkg::REQ_CHECK, 32'h0B00_0000, 32'h0, 32'h0, 32'h0, '0);
        // zero mask matches every address
        send_item(ibt_pkg::REQ_ADD, 32'h1234_5678, 32'h0, 32'hFFFF_FFFF, 32'h0, '0);
        send_item(ibt_pkg::REQ_CHECK, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, '0);
        send_item(ibt_pkg::REQ_DEL, 32'h0, 32'h0, 32'h0, 32'h0, 6'd63);  // far out of range
        send_item(ibt_pkg::REQ_DEL, 32'h0, 32'h0, 32'h0, 32'h0, 6'd3);   // index == count
        send_item(ibt_pkg::REQ_DEL, 32'h0, 32'h0, 32'h0, 32'h0, 6'd2);   // last entry
        send_item(ibt_pkg::REQ_CHECK, 32'h0, 32'h0, 32'h0, 32'd5, '0);
        send_item(ibt_pkg::REQ_DEL, 32'h0, 32'h0, 32'h0, 32'h0, 6'd0);   // shift down
        send_item(ibt_pkg::REQ_CHECK, 32'h0AFF_FFFF, 32'h0, 32'h0, 32'h0, '0);
        send_item(REQ_UNUSED, 32'h0, 32'h0, 32'h0, 32'h0, '0);
        send_item(ibt_pkg::REQ_DEL, 32'h0, 32'h0, 32'h0, 32'h0, 6'd0);
        send_item(ibt_pkg::REQ_CHECK, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, '0);
    endtask

    // Fill to the depth, overflow, and exercise the longest shift and scan.
    task automatic test_full_table();
        clock_now = $urandom;
        while (ban_count < ibt_pkg::TABLE_DEPTH)
            send_item(ibt_pkg::REQ_ADD, $urandom, prefix_mask($urandom_range(16, 32)),
                      pick_expiry(), $urandom, ibt_pkg::IDX_W'($urandom));
        repeat (2)
            send_item(ibt_pkg::REQ_ADD, $urandom, $urandom, $urandom, $urandom,
                      ibt_pkg::IDX_W'($urandom));
        send_item(ibt_pkg::REQ_CHECK, ban_list[ibt_pkg::TABLE_DEPTH - 1].addr, '0, '0,
                  clock_now, '0);
        send_item(ibt_pkg::REQ_CHECK, $urandom, '0, '0, $urandom, '0);
        send_item(ibt_pkg::REQ_DEL, '0, '0, '0, '0, 6'd0);
        send_item(ibt_pkg::REQ_DEL, '0, '0, '0, '0, ibt_pkg::IDX_W'(ban_count - 1));
        repeat (2)
            send_item(ibt_pkg::REQ_ADD, $urandom, random_mask(), pick_expiry(), $urandom, '0);
        send_item(ibt_pkg::REQ_DEL, '0, '0, '0, '0, 6'd63);
        send_item(ibt_pkg::REQ_CHECK, ban_list[0].addr, '0, '0, clock_now, '0);
    endtask

    // Bulk random traffic in alternating fill and drain blocks.
    task automatic test_random_mix();
        for (int i = 0; i < 1700; i++)
            send_random_request(((i / 150) % 2) == 0);
    endtask

    // Closing stretch with no gaps and no stalls.
    task automatic test_back_to_back();
        idle_en = 1'b0;
        for (int i = 0; i < 200; i++)
            send_random_request(((i / 50) % 2) == 0);
    endtask

    // Receiver: stall in bursts of random length while idling is on.
    always @(negedge aclk) begin
        if (idle_en && stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(0, 15);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each accepted result item with the oldest owed verdict.
    always @(posedge aclk) begin
        ibt_pkg::ibt_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_verdicts.size() == 0) begin
                $error("result item with no request pending: tdata %h", m_axis_tdata);
                error_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (m_axis_tdata[0] !== want.ok) begin
                    $error("ok: expected %0d, got %0d", want.ok, m_axis_tdata[0]);
                    error_count++;
                end
                if (m_axis_tdata[1] !== want.banned) begin
                    $error("banned: expected %0d, got %0d", want.banned, m_axis_tdata[1]);
                    error_count++;
                end
                if (m_axis_tdata[2 +: ibt_pkg::CNT_W] !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, m_axis_tdata[2 +: ibt_pkg::CNT_W]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** ip_ban_table_matcher: FAILED **");
            $finish;
        end
    end

    initial begin
        // hold reset low, then release it at a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_full_table();
        test_random_mix();
        test_back_to_back();

        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        // wait out every owed verdict, then a scan's worth for stray items
        while (pending_verdicts.size() != 0) @(posedge aclk);
        if (pending_verdicts.size() != 0) error_count++;
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("** ip_ban_table_matcher: PASSED **");
        end else begin
            $display("** ip_ban_table_matcher: FAILED **");
        end
        $finish;
    end

endmodule
